[src/lzbd_pkg.sv]
// Shared types and constants for the LZ back-reference decompressor.
// No dependencies.
`timescale 1ns / 1ps

package lzbd_pkg;

  localparam int CNT_W      = 24;
  localparam int HIST_DEPTH = 16384;           // power of two
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int OFF_BITS   = 13;
  localparam int LIT_BITS   = 8;
  localparam int EXT_BITS   = 8;
  localparam int DIST_BIAS  = 3;
  localparam int MIN_COPY   = 3;
  localparam int QUEUE_DEPTH = 3;

  typedef enum logic [2:0] {
    ST_BYTE = 3'd0,
    ST_DIST = 3'd1,
    ST_BUSY = 3'd2,
    ST_DONE = 3'd3,
    ST_SAT  = 3'd4
  } status_t;

  typedef struct packed {
    logic               is_copy;
    logic [7:0]         lit_byte;
    status_t            status;
    logic               last;
    logic [HIST_AW-1:0] wr_addr;
  } lzbd_s1_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_t    status;
    logic       last;
  } lzbd_res_t;

endpackage

[src/lz_backref_vle_decompressor.sv]
// Top level of the LZ back-reference decompressor with variable-length copies.
// Depends on lzbd_pkg, lzbd_parser, lzbd_history, lzbd_out_queue.
//
//   channel  ports                                   direction
//   cfg      cfg_valid cfg_ready cfg_data            write body_length
//   in       in_valid in_ready in_req_type in_code_bit   bit or drain tick
//   out      out_valid out_ready out_data_byte out_status out_last  result
//
// One transaction per cycle while in_ready is high; a result passes through
// the registered history read and result stage, then the result queue.
// Synchronous active-low reset; history contents are not cleared.
// in_ready drops only when the result queue entries plus the stage in flight
// reach the three-entry queue depth; output stalls never lose results.
`timescale 1ns / 1ps

module lz_backref_vle_decompressor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lzbd_pkg::CNT_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_req_type,
  input  logic                       in_code_bit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_data_byte,
  output logic [2:0]                 out_status,
  output logic                       out_last
);
  import lzbd_pkg::*;

  logic               accept;
  logic               rd_en;
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         rd_data;
  logic               s1_valid;
  lzbd_s1_t           s1;
  lzbd_res_t          res;
  lzbd_res_t          head;
  logic [1:0]         q_count;
  logic               hist_we;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = ({1'b0, q_count} + {2'b00, s1_valid}) < 3'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  lzbd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .accept   (accept),
    .req_type (in_req_type),
    .code_bit (in_code_bit),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  assign res.data_byte = s1.is_copy ? rd_data : s1.lit_byte;
  assign res.status    = s1.status;
  assign res.last      = s1.last;
  assign hist_we       = s1_valid && (s1.status == ST_BYTE);

  lzbd_history u_history (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s1.wr_addr),
    .wdata (res.data_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign pop = out_valid && out_ready;

  lzbd_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_data_byte = head.data_byte;
  assign out_status    = head.status;
  assign out_last      = head.last;

endmodule

[src/lzbd_history.sv]
// History byte store: one write port, one registered read port.
// Depends on lzbd_pkg.
`timescale 1ns / 1ps

module lzbd_history (
  input  logic                        clk,
  input  logic                        we,
  input  logic [lzbd_pkg::HIST_AW-1:0] waddr,
  input  logic [7:0]                  wdata,
  input  logic                        re,
  input  logic [lzbd_pkg::HIST_AW-1:0] raddr,
  output logic [7:0]                  rdata
);
  import lzbd_pkg::*;

  logic [7:0] mem [HIST_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/lzbd_parser.sv]
// Bitstream parser: decode state, length accumulation, history read issue
// and the registered result stage. Depends on lzbd_pkg.
`timescale 1ns / 1ps

module lzbd_parser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lzbd_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         accept,
  input  logic                         req_type,
  input  logic                         code_bit,
  output logic                         rd_en,
  output logic [lzbd_pkg::HIST_AW-1:0] rd_addr,
  output logic                         s1_valid,
  output lzbd_pkg::lzbd_s1_t           s1
);
  import lzbd_pkg::*;

  typedef enum logic [4:0] {
    PH_FLAG = 5'b00001,
    PH_LIT  = 5'b00010,
    PH_OFF  = 5'b00100,
    PH_LVL  = 5'b01000,
    PH_EXT  = 5'b10000
  } phase_t;

  localparam logic [3:0] LVL_BITS [4] = '{4'd2, 4'd3, 4'd5, 4'd8};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  function automatic logic [CNT_W:0] add_len(input logic [CNT_W-1:0] cur,
                                             input logic [7:0] v);
    logic [CNT_W:0] sum;
    sum = {1'b0, cur} + (CNT_W+1)'(v);
    if (sum[CNT_W]) begin
      add_len = {1'b1, CNT_MAX};
    end else begin
      add_len = sum;
    end
  endfunction

  logic [CNT_W-1:0] body_length_r;
  phase_t           phase_r, phase_nxt;
  logic [3:0]       bits_r, bits_nxt;
  logic [12:0]      shift_r, shift_nxt;
  logic [13:0]      dist_r, dist_nxt;
  logic [1:0]       level_r, level_nxt;
  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;

  logic             res_valid;
  lzbd_s1_t         res;

  logic [12:0]      shift_new;
  logic [3:0]       bits_new;
  logic [CNT_W-1:0] done_inc;
  logic [3:0]       w;
  logic [12:0]      mask;
  logic [12:0]      val;
  logic [CNT_W:0]   added;

  always_comb begin
    phase_nxt   = phase_r;
    bits_nxt    = bits_r;
    shift_nxt   = shift_r;
    dist_nxt    = dist_r;
    level_nxt   = level_r;
    pending_nxt = pending_r;
    done_nxt    = done_r;
    res_valid   = 1'b0;
    res.is_copy = 1'b0;
    res.lit_byte = 8'd0;
    res.status  = ST_BYTE;
    res.last    = 1'b0;
    res.wr_addr = done_r[HIST_AW-1:0];
    rd_en       = 1'b0;
    rd_addr     = HIST_AW'(done_r - CNT_W'(dist_r));
    shift_new   = {shift_r[11:0], code_bit};
    bits_new    = bits_r + 4'd1;
    done_inc    = done_r + CNT_W'(1);
    w           = LVL_BITS[level_r];
    mask        = (13'd1 << w) - 13'd1;
    val         = shift_new & mask;
    added       = add_len(pending_r, val[7:0]);

    if (accept) begin
      if (done_r >= body_length_r) begin
        res_valid  = 1'b1;
        res.status = ST_DONE;
      end else if (req_type) begin
        if (phase_r == PH_FLAG && pending_r != '0) begin
          res_valid = 1'b1;
          if (CNT_W'(dist_r) > done_r || 32'(dist_r) > HIST_DEPTH) begin
            pending_nxt = '0;
            res.status  = ST_DIST;
          end else begin
            pending_nxt = pending_r - CNT_W'(1);
            rd_en       = 1'b1;
            res.is_copy = 1'b1;
            res.last    = (done_inc == body_length_r);
            done_nxt    = done_inc;
          end
        end
      end else if (phase_r == PH_FLAG && pending_r != '0) begin
        res_valid  = 1'b1;
        res.status = ST_BUSY;
      end else begin
        case (phase_r)
          PH_FLAG: begin
            shift_nxt = '0;
            bits_nxt  = '0;
            phase_nxt = code_bit ? PH_OFF : PH_LIT;
          end
          PH_LIT: begin
            if (bits_new == 4'(LIT_BITS)) begin
              shift_nxt    = '0;
              bits_nxt     = '0;
              phase_nxt    = PH_FLAG;
              res_valid    = 1'b1;
              res.lit_byte = shift_new[7:0];
              res.last     = (done_inc == body_length_r);
              done_nxt     = done_inc;
            end else begin
              shift_nxt = shift_new;
              bits_nxt  = bits_new;
            end
          end
          PH_OFF: begin
            if (bits_new == 4'(OFF_BITS)) begin
              dist_nxt    = {1'b0, shift_new} + 14'(DIST_BIAS);
              shift_nxt   = '0;
              bits_nxt    = '0;
              pending_nxt = CNT_W'(MIN_COPY);
              level_nxt   = '0;
              phase_nxt   = PH_LVL;
            end else begin
              shift_nxt = shift_new;
              bits_nxt  = bits_new;
            end
          end
          PH_LVL: begin
            if (bits_new == w) begin
              shift_nxt   = '0;
              bits_nxt    = '0;
              pending_nxt = added[CNT_W-1:0];
              if (val != mask) begin
                phase_nxt = PH_FLAG;
              end else if (level_r == 2'd3) begin
                phase_nxt = PH_EXT;
              end else begin
                level_nxt = level_r + 2'd1;
              end
              if (added[CNT_W]) begin
                res_valid  = 1'b1;
                res.status = ST_SAT;
              end
            end else begin
              shift_nxt = shift_new;
              bits_nxt  = bits_new;
            end
          end
          PH_EXT: begin
            if (bits_new == 4'(EXT_BITS)) begin
              shift_nxt   = '0;
              bits_nxt    = '0;
              pending_nxt = added[CNT_W-1:0];
              if (shift_new[7:0] != 8'hFF) begin
                phase_nxt = PH_FLAG;
              end
              if (added[CNT_W]) begin
                res_valid  = 1'b1;
                res.status = ST_SAT;
              end
            end else begin
              shift_nxt = shift_new;
              bits_nxt  = bits_new;
            end
          end
          default: begin
            phase_nxt = PH_FLAG;
            shift_nxt = '0;
            bits_nxt  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_length_r <= '0;
      phase_r       <= PH_FLAG;
      bits_r        <= '0;
      shift_r       <= '0;
      dist_r        <= '0;
      level_r       <= '0;
      pending_r     <= '0;
      done_r        <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        body_length_r <= cfg_data;
      end
      phase_r   <= phase_nxt;
      bits_r    <= bits_nxt;
      shift_r   <= shift_nxt;
      dist_r    <= dist_nxt;
      level_r   <= level_nxt;
      pending_r <= pending_nxt;
      done_r    <= done_nxt;
      s1_valid  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= res;
  end

endmodule

[src/lzbd_out_queue.sv]
// Small result queue in front of the output channel.
// Depends on lzbd_pkg.
`timescale 1ns / 1ps

module lzbd_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lzbd_pkg::lzbd_res_t push_data,
  input  logic                pop,
  output logic                not_empty,
  output lzbd_pkg::lzbd_res_t head,
  output logic [1:0]          count
);
  import lzbd_pkg::*;

  lzbd_res_t  entries [QUEUE_DEPTH];
  logic [1:0] rd_ptr_r, wr_ptr_r, count_r;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    ptr_inc = (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  assign not_empty = (count_r != 2'd0);
  assign head      = entries[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule
